// ----- src/otc_pkg.sv -----
package otc_pkg;

  localparam int unsigned TRIM_W = 8;
  localparam int unsigned LEN_W  = 16;

  // 1499 * 16.5e6 / 10.5e6, rounded
  localparam logic [LEN_W-1:0]  TARGET_RESET = 16'd2356;
  localparam logic [TRIM_W-1:0] START_TRIAL  = 8'd128;
  localparam logic [TRIM_W-1:0] TRIM_MAX     = 8'd255;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  typedef struct packed {
    logic             op;
    logic [LEN_W-1:0] measured_length;
  } in_word_t;

  typedef struct packed {
    logic [TRIM_W-1:0] trim_value;
    logic              done_res;
    logic              ignored;
  } out_word_t;

endpackage

// ----- src/oscillator_trim_calibrator.sv -----
// Channel  Ports                               Word
// input    in_valid, in_ready, in_data         otc_pkg::in_word_t
// result   out_valid, out_ready, out_data      otc_pkg::out_word_t
// config   cfg_wr_en, cfg_wr_data              target_length
//
// One word in per cycle while in_ready is high; its result is registered and shows the cycle after.
// The whole search step sits between the input port and the result register.
// in_ready drops only while a result is held and out_ready is low.
// Synchronous reset: idle, target_length 2356, no result pending.
module oscillator_trim_calibrator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  otc_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output otc_pkg::out_word_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic [otc_pkg::LEN_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_BINARY   = 2'd1,
    PH_NEIGHBOR = 2'd2
  } phase_t;

  phase_t                     phase_r,    phase_nxt;
  logic [otc_pkg::TRIM_W-1:0] step_r,     step_nxt;
  logic [otc_pkg::TRIM_W-1:0] base_r,     base_nxt;
  logic [otc_pkg::TRIM_W-1:0] cursor_r,   cursor_nxt;
  logic [otc_pkg::TRIM_W-1:0] end_r,      end_nxt;
  logic [otc_pkg::TRIM_W-1:0] best_val_r, best_val_nxt;
  logic [otc_pkg::LEN_W-1:0]  best_dev_r, best_dev_nxt;
  logic [otc_pkg::LEN_W-1:0]  target_r;
  logic                       out_valid_r;
  otc_pkg::out_word_t         out_data_r, res;

  logic                       in_acc;
  logic [otc_pkg::TRIM_W-1:0] base_t, step_t, cur_t;
  logic [otc_pkg::LEN_W-1:0]  dev;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    base_nxt     = base_r;
    cursor_nxt   = cursor_r;
    end_nxt      = end_r;
    best_val_nxt = best_val_r;
    best_dev_nxt = best_dev_r;
    res          = '0;
    base_t       = (in_data.measured_length < target_r) ? base_r + step_r : base_r;
    step_t       = step_r >> 1;
    cur_t        = (base_t == '0) ? '0 : base_t - 1'b1;
    dev          = (in_data.measured_length >= target_r) ?
                   in_data.measured_length - target_r :
                   target_r - in_data.measured_length;
    if (in_data.op == otc_pkg::OP_START) begin
      phase_nxt      = PH_BINARY;
      step_nxt       = otc_pkg::START_TRIAL;
      base_nxt       = '0;
      res.trim_value = otc_pkg::START_TRIAL;
    end else begin
      unique case (phase_r)
        PH_BINARY: begin
          base_nxt = base_t;
          step_nxt = step_t;
          if (step_t != '0) begin
            res.trim_value = base_t + step_t;
          end else begin
            best_val_nxt   = base_t;
            best_dev_nxt   = in_data.measured_length;
            cursor_nxt     = cur_t;
            end_nxt        = (base_t == otc_pkg::TRIM_MAX) ? otc_pkg::TRIM_MAX
                                                           : base_t + 1'b1;
            phase_nxt      = PH_NEIGHBOR;
            res.trim_value = cur_t;
          end
        end
        PH_NEIGHBOR: begin
          if (dev < best_dev_r) begin
            best_dev_nxt = dev;
            best_val_nxt = cursor_r;
          end
          if (cursor_r >= end_r) begin
            phase_nxt      = PH_IDLE;
            res.trim_value = best_val_nxt;
            res.done_res   = 1'b1;
          end else begin
            cursor_nxt     = cursor_r + 1'b1;
            res.trim_value = cursor_r + 1'b1;
          end
        end
        default: begin
          phase_nxt   = PH_IDLE;
          res.ignored = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      step_r      <= '0;
      base_r      <= '0;
      cursor_r    <= '0;
      end_r       <= '0;
      best_val_r  <= '0;
      best_dev_r  <= '0;
      target_r    <= otc_pkg::TARGET_RESET;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        step_r      <= step_nxt;
        base_r      <= base_nxt;
        cursor_r    <= cursor_nxt;
        end_r       <= end_nxt;
        best_val_r  <= best_val_nxt;
        best_dev_r  <= best_dev_nxt;
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BINARY |-> $onehot(step_r))
    else $error("binary step not a single bit");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_NEIGHBOR |-> cursor_r <= end_r)
    else $error("neighbour cursor past end");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.op == otc_pkg::OP_START |=>
      out_valid_r && out_data_r.trim_value == otc_pkg::START_TRIAL &&
      phase_r == PH_BINARY)
    else $error("start did not open search");

  a_idle_meas: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.op == otc_pkg::OP_MEASURE && phase_r == PH_IDLE |=>
      out_valid_r && out_data_r.ignored && phase_r == PH_IDLE)
    else $error("idle measurement not flagged");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_nxt == PH_NEIGHBOR && res.done_res |-> 1'b0)
    else $error("done while search continues");
`endif

endmodule

// ----- tb/sv/tb_oscillator_trim_calibrator.sv -----
module tb_oscillator_trim_calibrator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASE_WORDS    = 150;

  typedef enum logic [1:0] {SRCH_IDLE, SRCH_BINARY, SRCH_NEIGHBOUR} srch_phase_t;
  typedef enum int {MEAS_NEAR, MEAS_ANY, MEAS_LOW, MEAS_HIGH} meas_mode_t;

  class trim_search_checker;
    logic [otc_pkg::LEN_W-1:0]  target;
    srch_phase_t                phase;
    logic [otc_pkg::TRIM_W-1:0] step;
    logic [otc_pkg::TRIM_W-1:0] base;
    logic [otc_pkg::TRIM_W-1:0] cursor;
    logic [otc_pkg::TRIM_W-1:0] last_trial;
    logic [otc_pkg::TRIM_W-1:0] best_trim;
    logic [otc_pkg::LEN_W-1:0]  best_dev;
    otc_pkg::out_word_t         trims_due[$];
    int                         faults;

    function new();
      target     = otc_pkg::TARGET_RESET;
      phase      = SRCH_IDLE;
      step       = '0;
      base       = '0;
      cursor     = '0;
      last_trial = '0;
      best_trim  = '0;
      best_dev   = '0;
      faults     = 0;
    endfunction

    function bit busy();
      return phase != SRCH_IDLE;
    endfunction

    function int pending();
      return trims_due.size();
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void note_word(otc_pkg::in_word_t w);
      otc_pkg::out_word_t        e;
      logic [otc_pkg::LEN_W-1:0] dev;
      e = '0;
      if (w.op == otc_pkg::OP_START) begin
        phase = SRCH_BINARY;
        step = otc_pkg::START_TRIAL;
        base = '0;
        e.trim_value = base + step;
      end else if (phase == SRCH_BINARY) begin
        if (w.measured_length < target) begin
          base = base + step;
        end
        step = step >> 1;
        if (step != 0) begin
          e.trim_value = base + step;
        end else begin
          // raw measurement seeds the best deviation
          best_trim = base;
          best_dev = w.measured_length;
          cursor = (base == 0) ? base : base - 1'b1;
          last_trial = (base == otc_pkg::TRIM_MAX) ? base : base + 1'b1;
          phase = SRCH_NEIGHBOUR;
          e.trim_value = cursor;
        end
      end else if (phase == SRCH_NEIGHBOUR) begin
        dev = (w.measured_length >= target) ? w.measured_length - target
                                            : target - w.measured_length;
        if (dev < best_dev) begin
          best_dev = dev;
          best_trim = cursor;
        end
        if (cursor >= last_trial) begin
          phase = SRCH_IDLE;
          e.trim_value = best_trim;
          e.done_res = 1'b1;
        end else begin
          cursor = cursor + 1'b1;
          e.trim_value = cursor;
        end
      end else begin
        phase = SRCH_IDLE;
        e.ignored = 1'b1;
      end
      trims_due.push_back(e);
    endfunction

    function void check_word(otc_pkg::out_word_t got);
      otc_pkg::out_word_t e;
      if (trims_due.size() == 0) begin
        flag($sformatf("unexpected word: trim %0d done %0b ignored %0b",
                       got.trim_value, got.done_res, got.ignored));
      end else begin
        e = trims_due.pop_front();
        if (got.trim_value != e.trim_value || got.done_res != e.done_res ||
            got.ignored != e.ignored) begin
          flag($sformatf("mismatch: trim %0d/%0d done %0b/%0b ignored %0b/%0b (exp/got)",
                         e.trim_value, got.trim_value, e.done_res, got.done_res,
                         e.ignored, got.ignored));
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  otc_pkg::in_word_t         in_data;
  logic                      out_valid;
  logic                      out_ready;
  otc_pkg::out_word_t        out_data;
  logic                      cfg_wr_en;
  logic [otc_pkg::LEN_W-1:0] cfg_wr_data;

  trim_search_checker sb;
  int                 quiet_cycles;
  int                 items;
  int                 stall_pct;
  bit                 sender_gaps;
  bit                 hold_results;

  oscillator_trim_calibrator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [otc_pkg::LEN_W-1:0] pick_length(
    meas_mode_t mode, logic [otc_pkg::LEN_W-1:0] tgt);
    int v;
    case (mode)
      MEAS_NEAR: begin
        v = int'(tgt) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      MEAS_LOW: begin
        v = (tgt == 0) ? 0 : $urandom_range(tgt - 1'b1, 0);
      end
      MEAS_HIGH: begin
        v = $urandom_range(65535, tgt);
      end
      default: begin
        v = $urandom_range(65535);
      end
    endcase
    return v[otc_pkg::LEN_W-1:0];
  endfunction

  // tasks below are entered and left at a falling edge
  task automatic offer(input logic op, input logic [otc_pkg::LEN_W-1:0] len);
    int                n;
    otc_pkg::in_word_t w;
    n = sender_gaps ? pause_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    w.op = op;
    w.measured_length = len;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_target(input logic [otc_pkg::LEN_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.target = v;
    @(negedge clk);
  endtask

  // cut < 0 runs the search to completion
  task automatic run_search(input meas_mode_t mode, input bit mixed, input int cut);
    int         sent;
    meas_mode_t m;
    offer(otc_pkg::OP_START, pick_length(MEAS_ANY, '0));
    sent = 0;
    while (sb.busy() && sent != cut) begin
      m = mixed ? meas_mode_t'($urandom_range(3)) : mode;
      offer(otc_pkg::OP_MEASURE, pick_length(m, sb.target));
      sent++;
    end
    items += sent + 1;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        out_ready <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat (pause_len()) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int                        r;
    logic [otc_pkg::LEN_W-1:0] tgt;
    sb = new();
    quiet_cycles = 0;
    items = 0;
    stall_pct = 30;
    sender_gaps = 1'b1;
    hold_results = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer(otc_pkg::OP_MEASURE, 16'hFFFF);          // idle: flagged only
    offer(otc_pkg::OP_START, 16'hFFFF);
    repeat (8) offer(otc_pkg::OP_MEASURE, 16'h0000);
    offer(otc_pkg::OP_MEASURE, otc_pkg::TARGET_RESET);  // top end: pass is 254..255
    offer(otc_pkg::OP_MEASURE, 16'hFFFF);
    offer(otc_pkg::OP_START, 16'h0000);
    offer(otc_pkg::OP_MEASURE, 16'h0000);
    offer(otc_pkg::OP_MEASURE, 16'hFFFF);
    offer(otc_pkg::OP_START, 16'h5A5A);            // restart mid-search
    repeat (8) offer(otc_pkg::OP_MEASURE, 16'hFFFF);
    // bottom end, equal deviations
    offer(otc_pkg::OP_MEASURE, otc_pkg::TARGET_RESET + 1'b1);
    offer(otc_pkg::OP_MEASURE, otc_pkg::TARGET_RESET - 1'b1);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p)
        0: tgt = otc_pkg::TARGET_RESET;
        1: tgt = '0;
        2: tgt = '1;
        5: begin
          r = $urandom_range(20);
          tgt = r[otc_pkg::LEN_W-1:0];
        end
        6: begin
          r = $urandom_range(65535, 65500);
          tgt = r[otc_pkg::LEN_W-1:0];
        end
        default: begin
          r = $urandom_range(65535);
          tgt = r[otc_pkg::LEN_W-1:0];
        end
      endcase
      write_target(tgt);
      sender_gaps = (p % 4 != 2);
      stall_pct = (p % 4 == 2) ? 0 : ((p % 2 == 1) ? 50 : 25);
      if (p == 3) begin
        // long receiver hold while words keep coming
        sender_gaps = 1'b0;
        hold_results = 1'b1;
        repeat (3) run_search(MEAS_NEAR, 1'b1, -1);
        sender_gaps = 1'b1;
      end
      while (items < (p + 1) * PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 78) begin
          run_search(meas_mode_t'($urandom_range(3)), $urandom_range(3) == 0, -1);
        end else if (r < 90) begin
          run_search(meas_mode_t'($urandom_range(3)), 1'b1, $urandom_range(10, 1));
        end else if (r < 98) begin
          repeat ($urandom_range(3, 1))
            offer(otc_pkg::OP_MEASURE, pick_length(MEAS_ANY, '0));
        end else begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
